[rtl/leb_pkg.sv]
// ----------------------------------------------------------------------------
// leb_pkg
// Shared constants, operation codes and controller/datapath types for the
// line edit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package leb_pkg;

    // Store geometry.
    localparam int LINE_LENGTH = 128;
    localparam int ADDR_W      = $clog2(LINE_LENGTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(LINE_LENGTH - 1);

    // Field widths of the request and response channels.
    localparam int FUNC_W = 3;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_BKSP   = 3'd1,
        FUNC_BACK   = 3'd2,
        FUNC_FWD    = 3'd3,
        FUNC_CLEAR  = 3'd4,
        FUNC_READ   = 3'd5
    } t_func;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the accepted request
        logic sweep_start;  // begin a pass over the store
        logic sweep_step;   // one entry of the pass
        logic read_issue;   // read one entry for a read request
        logic read_take;    // capture the read data
        logic quick;        // finish a request that needs no store access
        logic load_out;     // move the result into the response register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_sweep;
        logic need_read;
        logic sweep_last;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/leb_ifs.sv]
// ----------------------------------------------------------------------------
// leb_ifs
// Request and response channel interfaces of the line edit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

interface leb_req_if;
    logic                        valid;
    logic                        ready;
    logic [leb_pkg::FUNC_W-1:0]  func;
    logic [leb_pkg::CHAR_W-1:0]  char_in;
    logic [leb_pkg::IDX_W-1:0]   read_index;

    modport source (output valid, func, char_in, read_index, input ready);
    modport sink   (input valid, func, char_in, read_index, output ready);
endinterface

interface leb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        done_res;
    logic [leb_pkg::IDX_W-1:0]   cursor_pos;
    logic [leb_pkg::IDX_W-1:0]   line_length;
    logic [leb_pkg::CHAR_W-1:0]  char_out;

    modport source (output valid, done_res, cursor_pos, line_length, char_out, input ready);
    modport sink   (input valid, done_res, cursor_pos, line_length, char_out, output ready);
endinterface

`default_nettype wire

[rtl/leb_ctrl.sv]
// ----------------------------------------------------------------------------
// leb_ctrl
// Sequencer of the line edit buffer: accepts one request at a time, steps the
// datapath through it and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module leb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output leb_pkg::t_dp_cmd       o_cmd,
    input  wire leb_pkg::t_dp_sts  i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        o_cmd             = '0;
        o_cmd.capture     = accept;
        o_cmd.sweep_start = (r_state == ST_DECIDE) && i_sts.need_sweep;
        o_cmd.read_issue  = (r_state == ST_DECIDE) && !i_sts.need_sweep && i_sts.need_read;
        o_cmd.quick       = (r_state == ST_DECIDE) && !i_sts.need_sweep && !i_sts.need_read;
        o_cmd.read_take   = (r_state == ST_READ);
        o_cmd.sweep_step  = (r_state == ST_SWEEP);
        // The finished result waits here until the response register is free.
        o_cmd.load_out    = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_sts.need_sweep) begin
                    n_state = ST_SWEEP;
                end else if (i_sts.need_read) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_READ: begin
                n_state = ST_FINISH;
            end
            ST_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (o_cmd.load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/leb_datapath.sv]
// ----------------------------------------------------------------------------
// leb_datapath
// Line store, cursor and length registers of the line edit buffer, the
// shifting pass used by insert and backspace, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module leb_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire leb_pkg::t_dp_cmd             i_cmd,
    output leb_pkg::t_dp_sts                  o_sts,
    input  wire logic [leb_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [leb_pkg::CHAR_W-1:0]   i_char_in,
    input  wire logic [leb_pkg::IDX_W-1:0]    i_read_index,
    output logic                              o_done_res,
    output logic [leb_pkg::IDX_W-1:0]         o_cursor_pos,
    output logic [leb_pkg::IDX_W-1:0]         o_line_length,
    output logic [leb_pkg::CHAR_W-1:0]        o_char_out
);

    // Latched request.
    logic [leb_pkg::FUNC_W-1:0]  r_func;
    logic [leb_pkg::CHAR_W-1:0]  r_char;
    logic [leb_pkg::IDX_W-1:0]   r_ridx;

    // Editing state.
    logic [leb_pkg::ADDR_W-1:0]  r_cursor;
    logic [leb_pkg::ADDR_W-1:0]  r_length;

    // Store and its per-entry valid bits; an entry not yet written reads zero.
    logic [leb_pkg::CHAR_W-1:0]      r_mem [leb_pkg::LINE_LENGTH];
    logic [leb_pkg::LINE_LENGTH-1:0] r_valid;
    logic [leb_pkg::CHAR_W-1:0]      r_rdata;
    logic                            r_rvalid;

    // Pass state.
    logic [leb_pkg::ADDR_W-1:0]  r_m;
    logic [leb_pkg::CHAR_W-1:0]  r_prev;
    logic                        r_found;
    logic [leb_pkg::ADDR_W-1:0]  r_nlen;

    // Result staging and response register.
    logic                        r_res_done;
    logic [leb_pkg::CHAR_W-1:0]  r_res_char;
    logic                        r_o_done;
    logic [leb_pkg::IDX_W-1:0]   r_o_cursor;
    logic [leb_pkg::IDX_W-1:0]   r_o_length;
    logic [leb_pkg::CHAR_W-1:0]  r_o_char;

    logic                        is_insert;
    logic                        is_bksp;
    logic                        is_read;
    logic                        is_clear;
    logic                        ins_ok;
    logic                        bksp_ok;
    logic                        ridx_ok;
    logic [leb_pkg::CHAR_W-1:0]  cur_data;
    logic [leb_pkg::ADDR_W-1:0]  rd_addr;
    logic                        wr_en;
    logic [leb_pkg::ADDR_W-1:0]  wr_idx;
    logic [leb_pkg::CHAR_W-1:0]  wr_val;
    logic                        zero_hit;
    logic [leb_pkg::ADDR_W-1:0]  final_len;
    logic                        quick_done;
    logic [leb_pkg::ADDR_W-1:0]  quick_cursor;

    assign is_insert = (r_func == leb_pkg::FUNC_INSERT);
    assign is_bksp   = (r_func == leb_pkg::FUNC_BKSP);
    assign is_read   = (r_func == leb_pkg::FUNC_READ);
    assign is_clear  = (r_func == leb_pkg::FUNC_CLEAR);
    assign ins_ok    = is_insert && (r_cursor != leb_pkg::LAST_IDX);
    assign bksp_ok   = is_bksp && (r_cursor != '0);
    assign ridx_ok   = (32'(r_ridx) < 32'(leb_pkg::LINE_LENGTH));

    assign o_sts.need_sweep = ins_ok || bksp_ok;
    assign o_sts.need_read  = is_read && ridx_ok;
    assign o_sts.sweep_last = (r_m == leb_pkg::LAST_IDX);

    assign cur_data = r_rvalid ? r_rdata : '0;

    // During a pass the entry after the one arriving now is fetched.
    always_comb begin
        if (i_cmd.read_issue) begin
            rd_addr = leb_pkg::ADDR_W'(r_ridx);
        end else if (i_cmd.sweep_start || (r_m == leb_pkg::LAST_IDX)) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_m + leb_pkg::ADDR_W'(1);
        end
    end

    // Entry r_m arrives now and r_prev holds entry r_m - 1. Insert rewrites
    // entry r_m; backspace rewrites entry r_m - 1. The last slot stays zero.
    always_comb begin
        wr_en  = 1'b0;
        wr_idx = r_m;
        wr_val = cur_data;
        if (i_cmd.sweep_step) begin
            if (is_insert) begin
                wr_en  = 1'b1;
                wr_idx = r_m;
                if (r_m == leb_pkg::LAST_IDX) begin
                    wr_val = '0;
                end else if (r_m < r_cursor) begin
                    wr_val = cur_data;
                end else if (r_m == r_cursor) begin
                    wr_val = r_char;
                end else begin
                    wr_val = r_prev;
                end
            end else begin
                wr_en  = (r_m != '0);
                wr_idx = r_m - leb_pkg::ADDR_W'(1);
                wr_val = (r_m < r_cursor) ? r_prev : cur_data;
            end
        end
    end

    assign zero_hit = wr_en && (wr_val == '0) && !r_found;

    // Backspace never writes the last slot, which is zero, so the length
    // falls back to it when no earlier zero was written.
    always_comb begin
        if (r_found) begin
            final_len = r_nlen;
        end else if (zero_hit) begin
            final_len = wr_idx;
        end else begin
            final_len = leb_pkg::LAST_IDX;
        end
    end

    always_comb begin
        quick_done   = 1'b0;
        quick_cursor = r_cursor;
        case (r_func)
            leb_pkg::FUNC_BACK: begin
                if (r_cursor != '0) begin
                    quick_done   = 1'b1;
                    quick_cursor = r_cursor - leb_pkg::ADDR_W'(1);
                end
            end
            leb_pkg::FUNC_FWD: begin
                if (r_cursor < r_length) begin
                    quick_done   = 1'b1;
                    quick_cursor = r_cursor + leb_pkg::ADDR_W'(1);
                end
            end
            leb_pkg::FUNC_CLEAR: begin
                quick_done   = 1'b1;
                quick_cursor = '0;
            end
            default: begin
                quick_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_val;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= r_valid[rd_addr];
            if (i_cmd.quick && is_clear) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_length <= '0;
            r_m      <= '0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.quick) begin
                r_cursor <= quick_cursor;
                if (is_clear) begin
                    r_length <= '0;
                end
            end
            if (i_cmd.sweep_start) begin
                r_m     <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.sweep_step) begin
                r_m <= r_m + leb_pkg::ADDR_W'(1);
                if (zero_hit) begin
                    r_found <= 1'b1;
                end
                if (r_m == leb_pkg::LAST_IDX) begin
                    r_length <= final_len;
                    r_cursor <= is_insert ? r_cursor + leb_pkg::ADDR_W'(1)
                                          : r_cursor - leb_pkg::ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_char <= i_char_in;
            r_ridx <= i_read_index;
        end
        if (i_cmd.sweep_step) begin
            r_prev <= cur_data;
            if (zero_hit) begin
                r_nlen <= wr_idx;
            end
            if (r_m == leb_pkg::LAST_IDX) begin
                r_res_done <= 1'b1;
                r_res_char <= '0;
            end
        end
        if (i_cmd.quick) begin
            r_res_done <= quick_done;
            r_res_char <= '0;
        end
        if (i_cmd.read_take) begin
            r_res_done <= 1'b1;
            r_res_char <= cur_data;
        end
        if (i_cmd.load_out) begin
            r_o_done   <= r_res_done;
            r_o_cursor <= leb_pkg::IDX_W'(r_cursor);
            r_o_length <= leb_pkg::IDX_W'(r_length);
            r_o_char   <= r_res_char;
        end
    end

    assign o_done_res    = r_o_done;
    assign o_cursor_pos  = r_o_cursor;
    assign o_line_length = r_o_length;
    assign o_char_out    = r_o_char;

endmodule

`default_nettype wire

[rtl/line_edit_buffer.sv]
// ----------------------------------------------------------------------------
// line_edit_buffer
// Console line-edit store with a cursor: insert, backspace, cursor moves,
// clear and indexed read, one response per request.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers each with one response.
// Cursor moves, clear and refused edits finish without a store access; a read
// also passes through the state ST_READ, since the store's read data is
// registered. Insert and backspace pass over the whole 128-byte store through
// its single read port and single write port, one entry per cycle. The store
// needs no clearing pass: per-entry valid bits, cleared by reset and by the
// clear request, make unwritten entries read as zero. A finished response
// sits in an output register, so a new request is taken while it waits.
`default_nettype none

module line_edit_buffer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    leb_req_if.sink   i_req,
    leb_rsp_if.source o_rsp
);

    leb_pkg::t_dp_cmd dp_cmd;
    leb_pkg::t_dp_sts dp_sts;

    leb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    leb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_func        (i_req.func),
        .i_char_in     (i_req.char_in),
        .i_read_index  (i_req.read_index),
        .o_done_res    (o_rsp.done_res),
        .o_cursor_pos  (o_rsp.cursor_pos),
        .o_line_length (o_rsp.line_length),
        .o_char_out    (o_rsp.char_out)
    );

endmodule

`default_nettype wire

[rtl/leb_checker.sv]
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks of the line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module leb_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_req_valid,
    input wire logic                        i_req_ready,
    input wire logic                        i_rsp_valid,
    input wire logic                        i_rsp_ready,
    input wire logic                        i_rsp_done,
    input wire logic [leb_pkg::IDX_W-1:0]   i_rsp_cursor,
    input wire logic [leb_pkg::IDX_W-1:0]   i_rsp_length,
    input wire logic [leb_pkg::CHAR_W-1:0]  i_rsp_char
);

    // Reset empties the response register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_done) && $stable(i_rsp_cursor)
            && $stable(i_rsp_length) && $stable(i_rsp_char))
        else $error("stalled response changed");

    // Only a successful read returns a nonzero byte.
    a_char_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_char != '0) |-> i_rsp_done)
        else $error("nonzero byte on a refused request");

    // A request is worked on alone: the block is busy the cycle after taking one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in progress");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_done   (o_rsp.done_res),
    .i_rsp_cursor (o_rsp.cursor_pos),
    .i_rsp_length (o_rsp.line_length),
    .i_rsp_char   (o_rsp.char_out)
);

`default_nettype wire
